>>> sv/tcw_pkg.sv
// Shared types and constants for the text console character writer.
// Used by tcw_sweep and text_console_char_writer; no dependencies.
package tcw_pkg;

   // Cell and attribute constants
   localparam logic [15:0] BLANK_CELL = 16'h0720;
   localparam logic [7:0]  ATTR_RESET = 8'h0F;
   localparam logic [7:0]  CH_SPACE   = 8'h20;

   // Control characters
   localparam logic [7:0] CH_NEWLINE   = 8'h0A;
   localparam logic [7:0] CH_RETURN    = 8'h0D;
   localparam logic [7:0] CH_BACKSPACE = 8'h08;
   localparam logic [7:0] CH_FORMFEED  = 8'h0C;

   // Transaction mode carried in tuser
   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_READ  = 1'b1;

   // Write data source selected by the sweep engine
   localparam logic [1:0] WR_BLANK = 2'd0;
   localparam logic [1:0] WR_COPY  = 2'd1;
   localparam logic [1:0] WR_FILL  = 2'd2;

   // Packed field widths
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 32;

   // Sweep command from the sequencer
   typedef struct packed {
      logic start;
      logic scroll;
   } sweep_cmd_type;

   // Sweep status back to the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } sweep_sts_type;

   // Sweep write request (address travels separately)
   typedef struct packed {
      logic       en;
      logic [1:0] sel;
   } sweep_wr_type;

endpackage

>>> sv/tcw_screen_ram.sv
// Screen store: one write port and one registered read port.
// Depends on nothing but its parameters.
module tcw_screen_ram #(
   parameter int DEPTH = 2000,
   parameter int AW    = 11
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [15:0]   wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [15:0]   rd_data
);

   logic [15:0] cells_ff [DEPTH];
   logic [15:0] rd_data_ff;

   // Write one cell
   always_ff @(posedge clock) begin
      if (wr_en) begin
         cells_ff[wr_addr] <= wr_data;
      end
   end

   // Read one cell, registered
   always_ff @(posedge clock) begin
      rd_data_ff <= cells_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/tcw_sweep.sv
// Sweep engine: one address counter that walks the screen store for clear and scroll.
// Depends on tcw_pkg.
module tcw_sweep #(
   parameter int COLUMNS = 80,
   parameter int CELLS   = 2000,
   parameter int AW      = 11
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tcw_pkg::sweep_cmd_type cmd,
   output tcw_pkg::sweep_sts_type sts,
   output logic [AW-1:0]          rd_addr,
   output tcw_pkg::sweep_wr_type  wr,
   output logic [AW-1:0]          wr_addr
);

   localparam int PW = $clog2(CELLS + COLUMNS);

   logic          active_ff, active_in;
   logic          scroll_ff, scroll_in;
   logic [PW-1:0] ptr_ff, ptr_in;
   logic          pend_ff, pend_in;
   logic          pend_copy_ff, pend_copy_in;
   logic [AW-1:0] pend_addr_ff, pend_addr_in;
   logic          clear_step;
   logic          scroll_step;

   assign clear_step  = active_ff && !scroll_ff;
   assign scroll_step = active_ff && scroll_ff;

   // Advance the pointer; scroll reads one row ahead and writes in the following cycle
   always_comb begin
      active_in    = active_ff;
      scroll_in    = scroll_ff;
      ptr_in       = ptr_ff;
      pend_in      = 1'b0;
      pend_copy_in = pend_copy_ff;
      pend_addr_in = pend_addr_ff;
      if (cmd.start) begin
         active_in = 1'b1;
         scroll_in = cmd.scroll;
         ptr_in    = cmd.scroll ? PW'(COLUMNS) : '0;
      end else if (clear_step) begin
         ptr_in = ptr_ff + PW'(1);
         if (ptr_ff == PW'(CELLS - 1)) begin
            active_in = 1'b0;
         end
      end else if (scroll_step) begin
         pend_in      = 1'b1;
         pend_copy_in = ptr_ff < PW'(CELLS);
         pend_addr_in = AW'(ptr_ff - PW'(COLUMNS));
         ptr_in       = ptr_ff + PW'(1);
         if (ptr_ff == PW'(CELLS + COLUMNS - 1)) begin
            active_in = 1'b0;
         end
      end
   end

   // Control state; reset starts the clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b1;
         scroll_ff <= 1'b0;
         ptr_ff    <= '0;
         pend_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         scroll_ff <= scroll_in;
         ptr_ff    <= ptr_in;
         pend_ff   <= pend_in;
      end
   end

   // Pending write payload
   always_ff @(posedge clock) begin
      pend_copy_ff <= pend_copy_in;
      pend_addr_ff <= pend_addr_in;
   end

   // Drive write request and status
   always_comb begin
      wr.en   = clear_step || pend_ff;
      wr.sel  = tcw_pkg::WR_BLANK;
      wr_addr = AW'(ptr_ff);
      if (pend_ff) begin
         wr.sel  = pend_copy_ff ? tcw_pkg::WR_COPY : tcw_pkg::WR_FILL;
         wr_addr = pend_addr_ff;
      end
   end

   assign rd_addr  = AW'(ptr_ff);
   assign sts.busy = active_ff || pend_ff;
   assign sts.done = (clear_step && (ptr_ff == PW'(CELLS - 1))) || (pend_ff && !active_ff);

endmodule

>>> sv/text_console_char_writer.sv
// Top level of the text console character writer: sequencer, cursor and output register.
// Depends on tcw_pkg, tcw_sweep and tcw_screen_ram.
//
// Usage:
//   req_* carries one transaction per character or cell read. tuser is the mode
//   (0 writes char_code, 1 reads the cell at read_index). rsp_* returns one
//   transaction per request: the cell read (0 in write mode or out of range)
//   and the cursor after the request. csr_wen/csr_wdata set the attribute
//   used for written characters and the scroll fill.
// Throughput:
//   Printable characters and control codes but form feed, without scroll: result in
//   the cycle after acceptance; next request accepted then, once the result is taken.
//   Cell read: the registered read port of the store, then the output register.
//   Newline or wrap on the bottom row: the sweep counter moves one cell per cycle
//   through the store before the result is loaded. Form feed: a clearing pass runs first.
// Reset:
//   Synchronous. A clearing pass over all COLUMNS*ROWS cells (2000 by default) writes
//   0x0720 to every cell; req_tready stays low meanwhile.
// Stall:
//   A result waits in the output register; while idle, a new request is taken in the same
//   cycle the result is taken, or while the register is empty.
module text_console_char_writer #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                              clock,
   input  logic                              reset,
   // Configuration
   input  logic                              csr_wen,
   input  logic [7:0]                        csr_wdata,   // text_attribute
   // Request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [tcw_pkg::REQ_TDATA_W-1:0]   req_tdata,   // char_code[7:0], read_index[18:8]
   input  logic                              req_tuser,   // mode
   // Response channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [tcw_pkg::RSP_TDATA_W-1:0]   rsp_tdata    // cell_value[15:0],
                                                          // cursor_col[22:16],
                                                          // cursor_row[27:23]
);

   localparam int CELLS = COLUMNS * ROWS;
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = $clog2(COLUMNS);
   localparam int RW    = $clog2(ROWS);

   // Sequencer states
   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_READ   = 3'd2;
   localparam logic [2:0] ST_SCROLL = 3'd3;

   logic [2:0]    state_ff, state_in;
   logic [7:0]    attr_ff, attr_in;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [AW-1:0] base_ff, base_in;
   logic          reply_ff, reply_in;
   logic          in_range_ff, in_range_in;
   logic          rsp_tvalid_ff, rsp_tvalid_in;
   logic [tcw_pkg::RSP_TDATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   logic          req_accept;
   logic [7:0]    req_char;
   logic [10:0]   req_index;
   logic          chr_wr;
   logic          lf_req;
   logic          rsp_load;
   logic [15:0]   rsp_cell;

   tcw_pkg::sweep_cmd_type sweep_cmd;
   tcw_pkg::sweep_sts_type sweep_sts;
   tcw_pkg::sweep_wr_type  sweep_wr;
   logic [AW-1:0] sweep_rd_addr;
   logic [AW-1:0] sweep_wr_addr;

   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic [15:0]   ram_wr_data;
   logic [AW-1:0] ram_rd_addr;
   logic [15:0]   ram_rd_data;

   assign req_char   = req_tdata[7:0];
   assign req_index  = req_tdata[18:8];
   assign req_tready = (state_ff == ST_IDLE) && (!rsp_tvalid_ff || rsp_tready);
   assign req_accept = req_tvalid && req_tready;

   // Attribute register
   assign attr_in = csr_wen ? csr_wdata : attr_ff;

   // Cursor update and sequencer
   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      base_in      = base_ff;
      reply_in     = reply_ff;
      in_range_in  = in_range_ff;
      chr_wr       = 1'b0;
      lf_req       = 1'b0;
      rsp_load     = 1'b0;
      rsp_cell     = '0;
      sweep_cmd    = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            if (sweep_sts.done) begin
               state_in = ST_IDLE;
               rsp_load = reply_ff;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               if (req_tuser == tcw_pkg::MODE_READ) begin
                  in_range_in = 32'(req_index) < 32'(CELLS);
                  state_in    = ST_READ;
               end else begin
                  priority if (req_char == tcw_pkg::CH_NEWLINE) begin
                     col_in = '0;
                     lf_req = 1'b1;
                  end else if (req_char == tcw_pkg::CH_RETURN) begin
                     col_in = '0;
                  end else if (req_char == tcw_pkg::CH_BACKSPACE) begin
                     if (col_ff != '0) begin
                        col_in = col_ff - CW'(1);
                     end
                  end else if (req_char == tcw_pkg::CH_FORMFEED) begin
                     col_in           = '0;
                     row_in           = '0;
                     base_in          = '0;
                     reply_in         = 1'b1;
                     sweep_cmd.start  = 1'b1;
                     sweep_cmd.scroll = 1'b0;
                     state_in         = ST_CLEAR;
                  end else begin
                     chr_wr = 1'b1;
                     if (col_ff == CW'(COLUMNS - 1)) begin
                        col_in = '0;
                        lf_req = 1'b1;
                     end else begin
                        col_in = col_ff + CW'(1);
                     end
                  end
                  // Line feed: scroll on the bottom row, else step down
                  if (lf_req && (row_ff == RW'(ROWS - 1))) begin
                     sweep_cmd.start  = 1'b1;
                     sweep_cmd.scroll = 1'b1;
                     state_in         = ST_SCROLL;
                  end else if (lf_req) begin
                     row_in  = row_ff + RW'(1);
                     base_in = base_ff + AW'(COLUMNS);
                  end
                  if (state_in == ST_IDLE) begin
                     rsp_load = 1'b1;
                  end
               end
            end
         end
         ST_READ: begin
            rsp_cell = in_range_ff ? ram_rd_data : '0;
            rsp_load = 1'b1;
            state_in = ST_IDLE;
         end
         ST_SCROLL: begin
            if (sweep_sts.done) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register: load a result or hold until taken
   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      if (rsp_load) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = {4'b0000, 5'(row_in), 7'(col_in), rsp_cell};
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         attr_ff       <= tcw_pkg::ATTR_RESET;
         col_ff        <= '0;
         row_ff        <= '0;
         base_ff       <= '0;
         reply_ff      <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         attr_ff       <= attr_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         base_ff       <= base_in;
         reply_ff      <= reply_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      in_range_ff  <= in_range_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // Select store write source: sweep engine or character write
   always_comb begin
      ram_wr_en   = sweep_wr.en || chr_wr;
      ram_wr_addr = base_ff + AW'(col_ff);
      ram_wr_data = {attr_ff, req_char};
      if (sweep_wr.en) begin
         ram_wr_addr = sweep_wr_addr;
         unique case (sweep_wr.sel)
            tcw_pkg::WR_BLANK: ram_wr_data = tcw_pkg::BLANK_CELL;
            tcw_pkg::WR_COPY:  ram_wr_data = ram_rd_data;
            tcw_pkg::WR_FILL:  ram_wr_data = {attr_ff, tcw_pkg::CH_SPACE};
            default:           ram_wr_data = tcw_pkg::BLANK_CELL;
         endcase
      end
   end

   assign ram_rd_addr = (state_ff == ST_IDLE) ? AW'(req_index) : sweep_rd_addr;

   tcw_sweep #(
      .COLUMNS (COLUMNS),
      .CELLS   (CELLS),
      .AW      (AW)
   ) u_sweep (
      .clock   (clock),
      .reset   (reset),
      .cmd     (sweep_cmd),
      .sts     (sweep_sts),
      .rd_addr (sweep_rd_addr),
      .wr      (sweep_wr),
      .wr_addr (sweep_wr_addr)
   );

   tcw_screen_ram #(
      .DEPTH (CELLS),
      .AW    (AW)
   ) u_screen_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

`ifndef ASSERT_OFF
   // No request is taken while the store is being swept
   a_busy_blocks_req: assert property (@(posedge clock) disable iff (reset)
      sweep_sts.busy |-> !req_tready)
      else $error("request accepted during sweep");

   // Cursor stays on the screen
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      (32'(col_ff) < 32'(COLUMNS)) && (32'(row_ff) < 32'(ROWS)))
      else $error("cursor off screen");

   // Row base tracks the cursor row
   a_base_match: assert property (@(posedge clock) disable iff (reset)
      32'(base_ff) == 32'(row_ff) * COLUMNS)
      else $error("row base out of step with cursor row");

   // A result never overwrites one that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_tvalid_ff || rsp_tready))
      else $error("pending result overwritten");

   // Character writes never collide with a sweep write
   a_single_writer: assert property (@(posedge clock) disable iff (reset)
      chr_wr |-> !sweep_wr.en)
      else $error("store write collision");
`endif

endmodule
